[sv/sldx_pkg.sv]
// ----------------------------------------------------------------------------
// sldx_pkg
// Shared types and constants for the serial line discipline with XON/XOFF.
// ----------------------------------------------------------------------------
package sldx_pkg;

    localparam int QUEUE_DEPTH = 256;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = PTR_W + 1;
    localparam int HEAD_W      = 9;
    localparam int CMP_W       = (CNT_W > HEAD_W) ? CNT_W : HEAD_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 9;

    localparam logic [7:0] ASCII_MASK = 8'h7f;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_NL      = 8'h0a;

    localparam int MF_STRIP = 0;
    localparam int MF_INTR  = 1;
    localparam int MF_IXON  = 2;
    localparam int MF_IXANY = 3;
    localparam int MF_IXOFF = 4;
    localparam int MF_ICRNL = 5;
    localparam int MF_ONLCR = 6;

    typedef enum logic [1:0] {
        OP_RECV  = 2'd0,
        OP_POP   = 2'd1,
        OP_WRITE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        KIND_TX    = 3'd0,
        KIND_READ  = 3'd1,
        KIND_INTR  = 3'd2,
        KIND_EMPTY = 3'd3,
        KIND_HELD  = 3'd4
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE     = 3'd0,
        REG_INTR     = 3'd1,
        REG_STOP     = 3'd2,
        REG_START    = 3'd3,
        REG_HEADROOM = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OUT0,
        ST_OUT1
    } state_t;

    typedef struct packed {
        logic exec;
        logic second;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] nres;
        logic       two;
    } dp_stat_t;

endpackage

[sv/sldx_ctrl.sv]
// ----------------------------------------------------------------------------
// sldx_ctrl
// Controller: accepts one item, then presents its results one transfer at a time.
// ----------------------------------------------------------------------------
module sldx_ctrl
    import sldx_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd.exec   = 1'b0;
        cmd.second = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.exec = s_valid;
                if (s_valid && (stat.nres != 2'd0)) begin
                    state_next = ST_OUT0;
                end
            end
            ST_OUT0: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = stat.two ? ST_OUT1 : ST_IDLE;
                end
            end
            ST_OUT1: begin
                m_valid    = 1'b1;
                cmd.second = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/sldx_datapath.sv]
// ----------------------------------------------------------------------------
// sldx_datapath
// Configuration registers, receive queue, flow state and result slots.
// ----------------------------------------------------------------------------
module sldx_datapath
    import sldx_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [1:0]            s_op,
    input  logic [7:0]            s_data,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    output logic [2:0]            m_kind,
    output logic [7:0]            m_byte_out,
    output logic                  m_rx_stop,
    output logic                  m_last
);

    logic [6:0]       mode_reg;
    logic [7:0]       intr_reg;
    logic [7:0]       stop_reg;
    logic [7:0]       start_reg;
    logic [HEAD_W-1:0] headroom_reg;

    logic [7:0]       mem [QUEUE_DEPTH];
    logic [7:0]       rd_data_reg;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic             held_reg, held_next;
    logic             stopped_reg, stopped_next;
    logic             two_reg;
    logic [2:0]       kind0_reg, kind1_reg;
    logic [7:0]       byte0_reg, byte1_reg;

    logic [1:0]       nres;
    logic [2:0]       kind0, kind1;
    logic [7:0]       byte0, byte1;
    logic [7:0]       ch;
    logic [CNT_W-1:0] space;
    logic             mem_we;
    logic [7:0]       rd_byte;
    logic [2:0]       sel_kind;
    logic [7:0]       sel_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= 7'd103;
            intr_reg     <= 8'd3;
            stop_reg     <= 8'd19;
            start_reg    <= 8'd17;
            headroom_reg <= 9'd20;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MODE:     mode_reg     <= cfg_wdata[6:0];
                REG_INTR:     intr_reg     <= cfg_wdata[7:0];
                REG_STOP:     stop_reg     <= cfg_wdata[7:0];
                REG_START:    start_reg    <= cfg_wdata[7:0];
                REG_HEADROOM: headroom_reg <= cfg_wdata[HEAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        ch           = mode_reg[MF_STRIP] ? (s_data & ASCII_MASK) : s_data;
        space        = CNT_W'(QUEUE_DEPTH) - fill_reg;
        fill_next    = fill_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        held_next    = held_reg;
        stopped_next = stopped_reg;
        mem_we       = 1'b0;
        nres         = 2'd0;
        kind0        = KIND_TX;
        kind1        = KIND_TX;
        byte0        = 8'd0;
        byte1        = 8'd0;
        unique case (s_op)
            OP_RECV: begin
                priority if (mode_reg[MF_INTR] && (ch == intr_reg)) begin
                    nres  = 2'd1;
                    kind0 = KIND_INTR;
                end else if (mode_reg[MF_IXON] && mode_reg[MF_IXANY] && held_reg) begin
                    held_next = 1'b0;
                end else if (mode_reg[MF_IXON] && (ch == stop_reg)) begin
                    held_next = 1'b1;
                end else if (mode_reg[MF_IXON] && (ch == start_reg)) begin
                    held_next = 1'b0;
                end else if (space != '0) begin
                    mem_we    = 1'b1;
                    tail_next = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                    fill_next = fill_reg + 1'b1;
                    if ((CMP_W'(space) < CMP_W'(headroom_reg)) && !stopped_reg) begin
                        stopped_next = 1'b1;
                        if (mode_reg[MF_IXOFF]) begin
                            nres  = 2'd1;
                            byte0 = stop_reg;
                        end
                    end
                end else begin
                    nres = 2'd0;
                end
            end
            OP_POP: begin
                if (fill_reg == '0) begin
                    nres  = 2'd1;
                    kind0 = KIND_EMPTY;
                end else begin
                    head_next = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                    fill_next = fill_reg - 1'b1;
                    nres      = 2'd1;
                    kind0     = KIND_READ;
                    if ((CMP_W'(fill_reg) < CMP_W'(headroom_reg)) && stopped_reg) begin
                        stopped_next = 1'b0;
                        if (mode_reg[MF_IXOFF]) begin
                            nres  = 2'd2;
                            kind0 = KIND_TX;
                            byte0 = start_reg;
                            kind1 = KIND_READ;
                        end
                    end
                end
            end
            OP_WRITE: begin
                nres = 2'd1;
                if (held_reg) begin
                    kind0 = KIND_HELD;
                end else if (mode_reg[MF_ONLCR] && (s_data == CH_NL)) begin
                    nres  = 2'd2;
                    byte0 = CH_CR;
                    byte1 = s_data;
                end else begin
                    byte0 = s_data;
                end
            end
            default: begin
                nres = 2'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && mem_we) begin
            mem[tail_reg] <= ch;
        end
        if (cmd.exec) begin
            rd_data_reg <= mem[head_reg];
            kind0_reg   <= kind0;
            kind1_reg   <= kind1;
            byte0_reg   <= byte0;
            byte1_reg   <= byte1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            held_reg    <= 1'b0;
            stopped_reg <= 1'b0;
            two_reg     <= 1'b0;
        end else if (cmd.exec) begin
            fill_reg    <= fill_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            held_reg    <= held_next;
            stopped_reg <= stopped_next;
            two_reg     <= (nres == 2'd2);
        end
    end

    always_comb begin
        rd_byte = (mode_reg[MF_ICRNL] && (rd_data_reg == CH_CR)) ? CH_NL : rd_data_reg;
        sel_kind = cmd.second ? kind1_reg : kind0_reg;
        sel_byte = cmd.second ? byte1_reg : byte0_reg;
    end

    assign stat.nres  = nres;
    assign stat.two   = two_reg;
    assign m_kind     = sel_kind;
    assign m_byte_out = (sel_kind == KIND_READ) ? rd_byte : sel_byte;
    assign m_rx_stop  = stopped_reg;
    assign m_last     = cmd.second || !two_reg;

endmodule

[sv/serial_line_discipline_xon_xoff.sv]
// ----------------------------------------------------------------------------
// serial_line_discipline_xon_xoff
// Line discipline of one serial channel with XON/XOFF software flow control.
// ----------------------------------------------------------------------------
//   Channel   Handshake          Payload
//   s_        s_valid/s_ready    s_op, s_data
//   m_        m_valid/m_ready    m_kind, m_byte_out, m_rx_stop, m_last
//   cfg_      cfg_we             cfg_index, cfg_wdata
//
// An item is taken while the block is idle; an item with results (one or two)
// then holds the input off while the result sequencer presents the registered
// result slots one transfer at a time.
// Reset clears flags and queue pointers; queue contents are not cleared.
// A stalled result transfer holds the block and its outputs unchanged.
// ----------------------------------------------------------------------------
module serial_line_discipline_xon_xoff
    import sldx_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_op,
    input  logic [7:0]            s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_kind,
    output logic [7:0]            m_byte_out,
    output logic                  m_rx_stop,
    output logic                  m_last
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sldx_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sldx_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_op       (s_op),
        .s_data     (s_data),
        .cmd        (cmd),
        .stat       (stat),
        .m_kind     (m_kind),
        .m_byte_out (m_byte_out),
        .m_rx_stop  (m_rx_stop),
        .m_last     (m_last)
    );

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("Input accepted while a result is pending.");

    a_last_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> s_ready)
        else $error("Block not ready after the final result transfer.");

    a_second_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> (m_valid && m_last))
        else $error("Second result missing after the first transfer.");

    a_empty_no_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == KIND_EMPTY)) |-> m_last)
        else $error("Queue-empty result is not the only result.");

endmodule
